// File: design/hcfs_pkg.sv
`default_nettype none

package hcfs_pkg;

  // frame layout
  localparam int FRAME_BYTES = 21;
  localparam int SYNC_LEN    = 4;
  localparam int NCELLS      = FRAME_BYTES - 1;
  localparam int PAYLOAD_LEN = FRAME_BYTES - SYNC_LEN - 1;

  // counter and field widths
  localparam int FILL_W = $clog2(NCELLS + 1);
  localparam int CNT_W  = $clog2(PAYLOAD_LEN + 1);
  localparam int IDX_W  = 6;

  // sync word and crc polynomial
  localparam logic [7:0] SYNC0    = 8'hA1;
  localparam logic [7:0] SYNC1    = 8'hA2;
  localparam logic [7:0] SYNC2    = 8'hA3;
  localparam logic [7:0] SYNC3    = 8'hA4;
  localparam logic [7:0] CRC_POLY = 8'h07;

  // one cell of the window: a held byte and the crc from it to the newest byte
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] crc;
  } cell_t;

  // payload bytes of one frame, oldest in entry zero
  typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

  // one byte through the msb-first crc-8
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/hcfs_cell.sv
`default_nettype none

module hcfs_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  hcfs_pkg::cell_t prev_i,
  input  logic [7:0]     rx_i,
  output hcfs_pkg::cell_t cell_o
);
  import hcfs_pkg::*;

  cell_t cell_q;
  cell_t cell_d;

  // take the neighbor's byte and extend its crc run by the newest byte
  always_comb begin
    cell_d.data = prev_i.data;
    cell_d.crc  = crc8_byte(prev_i.crc, rx_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// File: design/hcfs_drain.sv
`default_nettype none

module hcfs_drain (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hcfs_pkg::payload_t  payload_i,
  output logic                empty_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // [7:0] payload_byte, [13:8] payload_index
  output logic                m_axis_tlast   // last_of_frame
);
  import hcfs_pkg::*;

  payload_t                 buf_q, buf_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     pop;

  assign pop = m_axis_tvalid && m_axis_tready;

  // load a whole frame, then shift one payload byte out per taken item
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      buf_d = payload_i;
      cnt_d = CNT_W'(PAYLOAD_LEN);
      idx_d = '0;
    end else if (pop) begin
      for (int k = 0; k < PAYLOAD_LEN - 1; k++) begin
        buf_d[k] = buf_q[k+1];
      end
      cnt_d = cnt_q - CNT_W'(1);
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // output item straight from the buffer head
  assign empty_o       = (cnt_q == '0);
  assign m_axis_tvalid = !empty_o;
  assign m_axis_tdata  = {2'b00, idx_q, buf_q[0]};
  assign m_axis_tlast  = (cnt_q == CNT_W'(1));

endmodule

`default_nettype wire

// File: design/header_crc8_frame_sync.sv
// header_crc8_frame_sync: finds frames in a received byte stream.
// Input: s_axis carries one raw byte per item in tdata[7:0]. Output: m_axis
// carries one payload byte per item, with its position in tdata[13:8] and
// tlast on the final payload byte of the frame.
// A frame is 21 bytes: sync word A1 A2 A3 A4, 16 payload bytes, and a CRC-8
// (poly 0x07, init 0) over the preceding 20 bytes. The window is a row of 20
// cells; each holds a byte and the crc from that byte to the newest, so a
// frame is checked in the cycle its last byte arrives.
// Latency: the first payload item is valid the cycle after the edge that
// accepts the crc byte; the 16 items then leave at one per cycle while
// m_axis_tready is high.
// Throughput: one byte per cycle while searching. While payload items of a
// found frame are pending, s_axis_tready is low, so input stalls until all
// 16 payload items are taken; a stalled receiver lengthens that stall.
// Reset clears the fill count and any pending payload; the window bytes are
// not cleared and are ignored until refilled. After a good frame the window
// starts empty; after a failed check the search slides on by one byte.
`default_nettype none

module header_crc8_frame_sync (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [13:8] payload_index
  output logic        m_axis_tlast    // last_of_frame
);
  import hcfs_pkg::*;

  cell_t             cells [NCELLS];
  cell_t             head;
  logic              accept;
  logic              full;
  logic              frame_ok;
  logic              empty;
  logic [FILL_W-1:0] fill_q, fill_d;
  payload_t          payload;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = empty;

  // row of window cells, newest at cell zero
  assign head.data = s_axis_tdata;
  assign head.crc  = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    if (i == 0) begin : g_first
      hcfs_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (accept),
        .prev_i (head),
        .rx_i   (s_axis_tdata),
        .cell_o (cells[i])
      );
    end else begin : g_next
      hcfs_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (accept),
        .prev_i (cells[i-1]),
        .rx_i   (s_axis_tdata),
        .cell_o (cells[i])
      );
    end
  end

  // frame check against the incoming crc byte
  assign full     = (fill_q == FILL_W'(NCELLS));
  assign frame_ok = full
                 && (cells[NCELLS-1].data == SYNC0)
                 && (cells[NCELLS-2].data == SYNC1)
                 && (cells[NCELLS-3].data == SYNC2)
                 && (cells[NCELLS-4].data == SYNC3)
                 && (cells[NCELLS-1].crc == s_axis_tdata);

  // payload bytes in arrival order
  always_comb begin
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      payload[k] = cells[NCELLS-1-SYNC_LEN-k].data;
    end
  end

  // fill count: empties on a good frame, saturates when the window is full
  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (frame_ok) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // payload output buffer
  hcfs_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && frame_ok),
    .payload_i     (payload),
    .empty_o       (empty),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // input is held off while payload items are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while payload pending");

  // a frame's last item leaves the buffer empty
  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("payload pending after last item");

  // every frame starts at payload index zero
  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (m_axis_tdata[13:8] == '0))
    else $error("frame does not start at index zero");

  // fill count never passes the window depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(NCELLS))
    else $error("fill count out of range");

endmodule

`default_nettype wire
